// File: sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Tilt to servo compare: shared package
// Types, widths and constant tables used by the roll angle pipeline.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int IN_W       = 16;
  localparam int FRAC_BITS  = 16;
  localparam int PRESHIFT   = 20;
  localparam int CORDIC_W   = 40;
  localparam int ANG_W      = 25;
  localparam int TAB_W      = 23;
  localparam int TABLE_SIZE = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int LIMIT_W    = 7;
  localparam int DEG_W      = 8;
  localparam int PROD_W     = 16;
  localparam int RECIP_SHIFT = 22;

  // Arctangent of 2^-i in degrees with 16 fractional bits.
  localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_SIZE] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0
  };

  localparam logic signed [ANG_W-1:0] ANG_90  = 25'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_180 = 25'sd11796480;

  localparam logic [DEG_W-1:0] DEG_0   = 8'd0;
  localparam logic [DEG_W-1:0] DEG_45  = 8'd45;
  localparam logic [DEG_W-1:0] DEG_90  = 8'd90;
  localparam logic [DEG_W-1:0] DEG_135 = 8'd135;
  localparam logic [DEG_W-1:0] DEG_180 = 8'd180;

  localparam logic signed [DEG_W:0] DEG9_MAX = 9'sd127;
  localparam logic signed [DEG_W:0] DEG9_MIN = -9'sd128;

  localparam logic [PROD_W-1:0] SCALE_MUL = 16'd134;
  localparam logic [PROD_W-1:0] CUT_MUL   = 16'd100;
  localparam logic [PROD_W-1:0] RECIP_100 = 16'd41944;
  localparam logic [9:0]        OUT_MAX   = 10'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_LIMIT = 3'd0,
    CFG_LOW_CUT     = 3'd1,
    CFG_LOW_VALUE   = 3'd2,
    CFG_HIGH_CUT    = 3'd3,
    CFG_HIGH_VALUE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ZERO_Y,
    MODE_AXIS_Z,
    MODE_DIAG,
    MODE_CORDIC
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  neg_y;
    logic  neg_z;
  } tsc_side_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]    angle_limit;
    logic [CFG_DATA_W-1:0] low_cut;
    logic [CFG_DATA_W-1:0] low_value;
    logic [CFG_DATA_W-1:0] high_cut;
    logic [CFG_DATA_W-1:0] high_value;
  } tsc_cfg_t;

endpackage

// File: sv/tsc_front.sv
// ----------------------------------------------------------------------------
// Tilt to servo compare: input stage
// Takes magnitudes of both axes, classifies exact cases and loads the
// first-quadrant vector for the rotation stages.
// ----------------------------------------------------------------------------
module tsc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid_in,
  input  logic signed [tsc_pkg::IN_W-1:0]      accel_y,
  input  logic signed [tsc_pkg::IN_W-1:0]      accel_z,
  output logic                                 valid_out,
  output logic signed [tsc_pkg::CORDIC_W-1:0]  x_out,
  output logic signed [tsc_pkg::CORDIC_W-1:0]  y_out,
  output tsc_pkg::tsc_side_t                   side_out
);
  import tsc_pkg::*;

  logic [IN_W:0] ext_y;
  logic [IN_W:0] ext_z;
  logic [IN_W:0] mag_y;
  logic [IN_W:0] mag_z;
  tsc_side_t     side_next;

  always_comb begin
    ext_y = {accel_y[IN_W-1], accel_y};
    ext_z = {accel_z[IN_W-1], accel_z};
    mag_y = accel_y[IN_W-1] ? (~ext_y + 1'b1) : ext_y;
    mag_z = accel_z[IN_W-1] ? (~ext_z + 1'b1) : ext_z;
    side_next.neg_y = accel_y[IN_W-1];
    side_next.neg_z = accel_z[IN_W-1];
    priority if (accel_y == '0) begin
      side_next.mode = MODE_ZERO_Y;
    end else if (accel_z == '0) begin
      side_next.mode = MODE_AXIS_Z;
    end else if (mag_y == mag_z) begin
      side_next.mode = MODE_DIAG;
    end else begin
      side_next.mode = MODE_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x_out    <= $signed(CORDIC_W'({mag_z, {PRESHIFT{1'b0}}}));
    y_out    <= $signed(CORDIC_W'({mag_y, {PRESHIFT{1'b0}}}));
    side_out <= side_next;
  end

endmodule

// File: sv/tsc_cordic_stage.sv
// ----------------------------------------------------------------------------
// Tilt to servo compare: vectoring rotation stage
// One micro-rotation that drives y towards zero and accumulates the angle.
// ----------------------------------------------------------------------------
module tsc_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 valid_in,
  input  logic signed [tsc_pkg::CORDIC_W-1:0]  x_in,
  input  logic signed [tsc_pkg::CORDIC_W-1:0]  y_in,
  input  logic signed [tsc_pkg::ANG_W-1:0]     ang_in,
  input  tsc_pkg::tsc_side_t                   side_in,
  output logic                                 valid_out,
  output logic signed [tsc_pkg::CORDIC_W-1:0]  x_out,
  output logic signed [tsc_pkg::CORDIC_W-1:0]  y_out,
  output logic signed [tsc_pkg::ANG_W-1:0]     ang_out,
  output tsc_pkg::tsc_side_t                   side_out
);
  import tsc_pkg::*;

  logic                       y_pos;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [ANG_W-1:0]    step;
  logic signed [CORDIC_W-1:0] x_next;
  logic signed [CORDIC_W-1:0] y_next;
  logic signed [ANG_W-1:0]    ang_next;

  always_comb begin
    y_pos = !y_in[CORDIC_W-1] && (y_in != '0);
    dx    = y_in >>> STAGE;
    dy    = x_in >>> STAGE;
    step  = $signed({2'b00, ATAN_TAB[STAGE]});
    if (y_pos) begin
      x_next   = x_in + dx;
      y_next   = y_in - dy;
      ang_next = ang_in + step;
    end else begin
      x_next   = x_in - dx;
      y_next   = y_in + dy;
      ang_next = ang_in - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x_out    <= x_next;
    y_out    <= y_next;
    ang_out  <= ang_next;
    side_out <= side_in;
  end

endmodule

// File: sv/tsc_back.sv
// ----------------------------------------------------------------------------
// Tilt to servo compare: output stages
// Folds the angle into whole degrees, clamps and scales it, and applies the
// cut window to form the servo compare value.
// ----------------------------------------------------------------------------
module tsc_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid_in,
  input  logic signed [tsc_pkg::ANG_W-1:0]   ang_in,
  input  tsc_pkg::tsc_side_t                 side_in,
  input  tsc_pkg::tsc_cfg_t                  cfg,
  output logic                               result_valid,
  output logic signed [tsc_pkg::DEG_W-1:0]   roll_degrees,
  output logic        [tsc_pkg::DEG_W-1:0]   servo_compare
);
  import tsc_pkg::*;

  // Stage A: whole degrees, signed and saturated.
  logic signed [ANG_W-1:0] a_clamp;
  logic signed [ANG_W-1:0] a_fold;
  logic [DEG_W-1:0]        mag;
  logic signed [DEG_W:0]   mag9;
  logic signed [DEG_W:0]   deg9;
  logic signed [DEG_W:0]   deg_sat9;
  logic                    valid_a;
  logic signed [DEG_W-1:0] deg_a;

  always_comb begin
    if (ang_in[ANG_W-1]) begin
      a_clamp = '0;
    end else if (ang_in > ANG_90) begin
      a_clamp = ANG_90;
    end else begin
      a_clamp = ang_in;
    end
    a_fold = side_in.neg_z ? (ANG_180 - a_clamp) : a_clamp;
    unique case (side_in.mode)
      MODE_ZERO_Y: mag = side_in.neg_z ? DEG_180 : DEG_0;
      MODE_AXIS_Z: mag = DEG_90;
      MODE_DIAG:   mag = side_in.neg_z ? DEG_135 : DEG_45;
      MODE_CORDIC: mag = a_fold[FRAC_BITS +: DEG_W];
    endcase
    mag9 = $signed({1'b0, mag});
    deg9 = side_in.neg_y ? -mag9 : mag9;
    if (deg9 > DEG9_MAX) begin
      deg_sat9 = DEG9_MAX;
    end else if (deg9 < DEG9_MIN) begin
      deg_sat9 = DEG9_MIN;
    end else begin
      deg_sat9 = deg9;
    end
  end

  // Stage B: clamp to the angle limit and scale.
  logic signed [DEG_W:0]   lim9;
  logic signed [DEG_W:0]   d9;
  logic signed [DEG_W:0]   dc9;
  logic signed [DEG_W:0]   s9;
  logic [PROD_W-1:0]       p_next;
  logic                    valid_b;
  logic signed [DEG_W-1:0] deg_b;
  logic [PROD_W-1:0]       p_b;

  always_comb begin
    lim9 = $signed({2'b00, cfg.angle_limit});
    d9   = $signed({deg_a[DEG_W-1], deg_a});
    if (d9 < -lim9) begin
      dc9 = -lim9;
    end else if (d9 > lim9) begin
      dc9 = lim9;
    end else begin
      dc9 = d9;
    end
    s9     = dc9 + lim9;
    p_next = {8'd0, s9[DEG_W-1:0]} * SCALE_MUL;
  end

  // Stage C: divide by one hundred and apply the cut window.
  logic [2*PROD_W-1:0]   quot_prod;
  logic [9:0]            q;
  logic [PROD_W-1:0]     low_thr;
  logic [PROD_W-1:0]     high_thr;
  logic [DEG_W-1:0]      r_next;

  always_comb begin
    quot_prod = {16'd0, p_b} * {16'd0, RECIP_100};
    q         = quot_prod[RECIP_SHIFT +: 10];
    low_thr   = {8'd0, cfg.low_cut} * CUT_MUL;
    high_thr  = {8'd0, cfg.high_cut} * CUT_MUL;
    priority if (p_b < low_thr) begin
      r_next = (cfg.low_value > cfg.high_cut) ? cfg.high_value : cfg.low_value;
    end else if (p_b > high_thr) begin
      r_next = cfg.high_value;
    end else if (q > OUT_MAX) begin
      r_next = OUT_MAX[DEG_W-1:0];
    end else begin
      r_next = q[DEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a      <= 1'b0;
      valid_b      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      valid_a      <= valid_in;
      valid_b      <= valid_a;
      result_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    deg_a         <= deg_sat9[DEG_W-1:0];
    deg_b         <= deg_a;
    p_b           <= p_next;
    roll_degrees  <= deg_b;
    servo_compare <= r_next;
  end

endmodule

// File: sv/tilt_to_servo_compare.sv
// The result strobe follows the accepting edge through the input stage,
// one register per rotation stage and three output stages.
// Throughput: one sample per cycle; busy is only high during reset.
// Reset clears all valid bits and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Tilt to servo compare: top level
// Roll angle of an accelerometer sample by vectoring rotation, mapped to a
// servo compare value through a configurable clamp and cut window.
// ----------------------------------------------------------------------------
module tilt_to_servo_compare #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tsc_pkg::IN_W-1:0]        accel_y,
  input  logic signed [tsc_pkg::IN_W-1:0]        accel_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [tsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [tsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                   result_valid,
  output logic signed [tsc_pkg::DEG_W-1:0]       roll_degrees,
  output logic        [tsc_pkg::DEG_W-1:0]       servo_compare
);
  import tsc_pkg::*;

  tsc_cfg_t cfg;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_limit <= 7'd45;
      cfg.low_cut     <= 8'd35;
      cfg.low_value   <= 8'd30;
      cfg.high_cut    <= 8'd90;
      cfg.high_value  <= 8'd95;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANGLE_LIMIT: cfg.angle_limit <= cfg_data[LIMIT_W-1:0];
        CFG_LOW_CUT:     cfg.low_cut     <= cfg_data;
        CFG_LOW_VALUE:   cfg.low_value   <= cfg_data;
        CFG_HIGH_CUT:    cfg.high_cut    <= cfg_data;
        CFG_HIGH_VALUE:  cfg.high_value  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic                       stg_valid [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] stg_x     [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] stg_y     [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]    stg_ang   [CORDIC_STAGES+1];
  tsc_side_t                  stg_side  [CORDIC_STAGES+1];

  tsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start && !busy),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .valid_out (stg_valid[0]),
    .x_out     (stg_x[0]),
    .y_out     (stg_y[0]),
    .side_out  (stg_side[0])
  );

  assign stg_ang[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    tsc_cordic_stage #(
      .STAGE (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stg_valid[i]),
      .x_in      (stg_x[i]),
      .y_in      (stg_y[i]),
      .ang_in    (stg_ang[i]),
      .side_in   (stg_side[i]),
      .valid_out (stg_valid[i+1]),
      .x_out     (stg_x[i+1]),
      .y_out     (stg_y[i+1]),
      .ang_out   (stg_ang[i+1]),
      .side_out  (stg_side[i+1])
    );
  end

  tsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .valid_in      (stg_valid[CORDIC_STAGES]),
    .ang_in        (stg_ang[CORDIC_STAGES]),
    .side_in       (stg_side[CORDIC_STAGES]),
    .cfg           (cfg),
    .result_valid  (result_valid),
    .roll_degrees  (roll_degrees),
    .servo_compare (servo_compare)
  );

`ifndef SYNTH
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, CORDIC_STAGES + 4))
    else $error("result strobe without a matching accepted sample");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(CORDIC_STAGES + 4) result_valid)
    else $error("accepted sample produced no result transfer");
`endif

endmodule

// File: tb/tilt_servo_checker.sv
// ----------------------------------------------------------------------------
// Tilt to servo compare: result checker
// Watches the sample, register and result channels of the block, follows the
// register writes, predicts the roll angle and servo compare value of every
// accepted sample and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tilt_servo_checker #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic signed [tsc_pkg::IN_W-1:0]        accel_y,
  input  logic signed [tsc_pkg::IN_W-1:0]        accel_z,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic        [tsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [tsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                   result_valid,
  input  logic signed [tsc_pkg::DEG_W-1:0]       roll_degrees,
  input  logic        [tsc_pkg::DEG_W-1:0]       servo_compare,
  output int                                     mismatches,
  output int                                     outstanding
);

  localparam int ATAN_ENTRIES = 28;

  localparam longint ATAN_DEG [ATAN_ENTRIES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [7:0] roll;
    logic        [7:0] compare;
  } servo_pose_t;

  tsc_pkg::tsc_cfg_t settings;
  servo_pose_t       pose_q[$];
  int                errs = 0;

  function automatic longint roll_angle(input longint y, input longint z);
    longint ay, az, xr, yr, dx, dy, acc, mag;
    int     i;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    if (y == 0) begin
      return (z < 0) ? 180 : 0;
    end
    if (z == 0) begin
      mag = 90;
    end else if (ay == az) begin
      mag = (z < 0) ? 135 : 45;
    end else begin
      xr  = az <<< 20;
      yr  = ay <<< 20;
      acc = 0;
      for (i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
        dx = yr >>> i;
        dy = xr >>> i;
        if (yr > 0) begin
          xr  = xr + dx;
          yr  = yr - dy;
          acc = acc + ATAN_DEG[i];
        end else begin
          xr  = xr - dx;
          yr  = yr + dy;
          acc = acc - ATAN_DEG[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(90) <<< 16)) acc = longint'(90) <<< 16;
      if (z < 0) acc = (longint'(180) <<< 16) - acc;
      mag = acc >>> 16;
    end
    return (y < 0) ? -mag : mag;
  endfunction

  function automatic servo_pose_t predict_pose(input logic signed [15:0] y,
                                               input logic signed [15:0] z,
                                               input tsc_pkg::tsc_cfg_t c);
    longint      deg, d, lim, p, q;
    logic [7:0]  r;
    servo_pose_t pose;
    deg = roll_angle(longint'(y), longint'(z));
    if (deg > 127) deg = 127;
    if (deg < -128) deg = -128;
    lim = longint'(c.angle_limit);
    d = deg;
    if (d < -lim) d = -lim;
    if (d > lim) d = lim;
    p = 134 * (d + lim);
    if (p < 100 * longint'(c.low_cut)) begin
      r = c.low_value;
      if (r > c.high_cut) r = c.high_value;
    end else if (p > 100 * longint'(c.high_cut)) begin
      r = c.high_value;
    end else begin
      q = p / 100;
      r = (q > 255) ? 8'd255 : 8'(q);
    end
    pose.roll    = 8'(deg);
    pose.compare = r;
    return pose;
  endfunction

  always @(posedge clk) begin
    servo_pose_t want;
    if (rst) begin
      settings.angle_limit = 7'd45;
      settings.low_cut     = 8'd35;
      settings.low_value   = 8'd30;
      settings.high_cut    = 8'd90;
      settings.high_value  = 8'd95;
      pose_q.delete();
    end else begin
      if (result_valid) begin
        if (pose_q.size() == 0) begin
          errs++;
          $display("%0t: result with no sample outstanding: roll %0d compare %0d",
                   $time, roll_degrees, servo_compare);
        end else begin
          want = pose_q.pop_front();
          if (roll_degrees !== want.roll) begin
            errs++;
            $display("%0t: roll_degrees expected %0d, actual %0d",
                     $time, $signed(want.roll), roll_degrees);
          end
          if (servo_compare !== want.compare) begin
            errs++;
            $display("%0t: servo_compare expected %0d, actual %0d",
                     $time, want.compare, servo_compare);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (tsc_pkg::cfg_reg_t'(cfg_index))
          tsc_pkg::CFG_ANGLE_LIMIT: settings.angle_limit = cfg_data[6:0];
          tsc_pkg::CFG_LOW_CUT:     settings.low_cut     = cfg_data;
          tsc_pkg::CFG_LOW_VALUE:   settings.low_value   = cfg_data;
          tsc_pkg::CFG_HIGH_CUT:    settings.high_cut    = cfg_data;
          tsc_pkg::CFG_HIGH_VALUE:  settings.high_value  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        pose_q.push_back(predict_pose(accel_y, accel_z, settings));
    end
    mismatches  <= errs;
    outstanding <= pose_q.size();
  end

endmodule

// File: tb/tilt_to_servo_compare_tb.sv
// ----------------------------------------------------------------------------
// Tilt to servo compare: testbench top
// Drives directed and random accelerometer samples through several register
// settings, with random idle bursts, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tilt_to_servo_compare_tb;

  localparam int STAGES       = 20;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 75;
  localparam int DIRECTED     = 24;
  localparam int SETTLE       = STAGES + 10;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [15:0] DIR_Y [DIRECTED] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768 + 16'sd32768, 16'sd1,
    -16'sd1, 16'sd32767, -16'sd32768, 16'sd7, -16'sd7, 16'sd7,
    -16'sd7, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd1,
    -16'sd1, 16'sd32767, -16'sd32768, 16'sd1000, -16'sd12345, 16'sd2
  };
  localparam logic signed [15:0] DIR_Z [DIRECTED] = '{
    16'sd0, 16'sd1, -16'sd1, -16'sd32768, 16'sd32767, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd7, -16'sd7,
    -16'sd7, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
    16'sd32767, 16'sd1, -16'sd1, -16'sd30000, 16'sd4321, -16'sd1
  };

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic signed [tsc_pkg::IN_W-1:0]       accel_y = '0;
  logic signed [tsc_pkg::IN_W-1:0]       accel_z = '0;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic        [tsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic        [tsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                                  result_valid;
  logic signed [tsc_pkg::DEG_W-1:0]      roll_degrees;
  logic        [tsc_pkg::DEG_W-1:0]      servo_compare;
  int                                    mismatches;
  int                                    outstanding;
  int                                    cycles = 0;

  tilt_to_servo_compare #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .accel_y(accel_y), .accel_z(accel_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .roll_degrees(roll_degrees),
    .servo_compare(servo_compare)
  );

  tilt_servo_checker #(.CORDIC_STAGES(STAGES)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .accel_y(accel_y), .accel_z(accel_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .roll_degrees(roll_degrees),
    .servo_compare(servo_compare),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** tilt_to_servo_compare: FAILED **");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [15:0] y, input logic signed [15:0] z);
    start   <= 1'b1;
    accel_y <= y;
    accel_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input tsc_pkg::cfg_reg_t idx, input logic [7:0] value,
                           input bit idle);
    if (idle && $urandom_range(0, 2) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_settings(input int phase, input bit idle);
    logic [7:0] lim, lcut, lval, hcut, hval;
    case (phase)
      1: begin lim = 8'd0;   lcut = 8'd0;   lval = 8'd0;   hcut = 8'd0;   hval = 8'd0;   end
      2: begin lim = 8'd127; lcut = 8'd0;   lval = 8'd255; hcut = 8'd255; hval = 8'd255; end
      3: begin lim = 8'd90;  lcut = 8'd255; lval = 8'd200; hcut = 8'd100; hval = 8'd7;   end
      4: begin lim = 8'd1;   lcut = 8'd1;   lval = 8'd77;  hcut = 8'd2;   hval = 8'd250; end
      5: begin lim = 8'd90;  lcut = 8'd0;   lval = 8'd0;   hcut = 8'd255; hval = 8'd0;   end
      default: begin
        lim  = 8'($urandom_range(0, 127));
        lcut = 8'($urandom_range(0, 255));
        lval = 8'($urandom_range(0, 255));
        hcut = 8'($urandom_range(0, 255));
        hval = 8'($urandom_range(0, 255));
      end
    endcase
    write_reg(tsc_pkg::CFG_ANGLE_LIMIT, lim, idle);
    write_reg(tsc_pkg::CFG_LOW_CUT, lcut, idle);
    write_reg(tsc_pkg::CFG_LOW_VALUE, lval, idle);
    write_reg(tsc_pkg::CFG_HIGH_CUT, hcut, idle);
    write_reg(tsc_pkg::CFG_HIGH_VALUE, hval, idle);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic void pick_sample(output logic signed [15:0] y,
                                      output logic signed [15:0] z);
    int a, b, m;
    case ($urandom_range(0, 9))
      5: begin
        a = int'($urandom_range(0, 16)) - 8;
        b = int'($urandom_range(0, 16)) - 8;
      end
      6: begin
        m = $urandom_range(1, 32767);
        a = $urandom_range(0, 1) ? m : -m;
        b = $urandom_range(0, 1) ? m : -m;
      end
      7: begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = 0;
        if ($urandom_range(0, 1)) begin
          b = a;
          a = 0;
        end
      end
      8: begin
        a = int'($urandom_range(0, 4000)) - 2000;
        b = int'($urandom_range(0, 65535)) - 32768;
      end
      9: begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 64)) - 32;
      end
      default: begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    y = 16'(a);
    z = 16'(b);
  endfunction

  initial begin
    logic signed [15:0] y, z;
    bit                 idle;
    int                 ph, n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < DIRECTED; n++) begin
      send_sample(DIR_Y[n], DIR_Z[n]);
    end
    for (ph = 0; ph < PHASES; ph++) begin
      idle = (ph != PHASES - 1);
      if (ph > 0) program_settings(ph, idle);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick_sample(y, z);
        if (idle && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        send_sample(y, z);
      end
      drain_results();
    end
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** tilt_to_servo_compare: PASSED **");
    end else begin
      $display("** tilt_to_servo_compare: FAILED **");
    end
    $finish;
  end

endmodule
